[hdl/rmc_pkg.sv]
package rmc_pkg;
  localparam int MAX_EDGES    = 1024;
  localparam int MAX_VERTICES = 256;

  localparam int VID_W   = 8;
  localparam int CUT_W   = 11;
  localparam int SEED_W  = 32;
  localparam int DRAW_W  = 20;
  localparam int TRIAL_W = 8;
  localparam logic [31:0] LFSR_MASK = 32'h8020_0003;

  localparam logic [1:0] CFG_TRIALS = 2'd0;
  localparam logic [1:0] CFG_SEED   = 2'd1;
  localparam logic [1:0] CFG_DRAWS  = 2'd2;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_INIT,
    ST_DRAW,
    ST_MOD,
    ST_EREAD,
    ST_EWAIT,
    ST_FINDA,
    ST_FINDA_W,
    ST_FINDB,
    ST_FINDB_W,
    ST_LINK,
    ST_CREAD,
    ST_CWAIT,
    ST_CFA,
    ST_CFA_W,
    ST_CFB,
    ST_CFB_W,
    ST_CNEXT,
    ST_TEND,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [CUT_W-1:0] min_cut;
    logic             graph_empty;
    logic             store_overflow;
  } result_t;

  function automatic logic [31:0] lfsr_step(input logic [31:0] v);
    lfsr_step = v[0] ? ((v >> 1) ^ LFSR_MASK) : (v >> 1);
  endfunction
endpackage

[hdl/rmc_if.sv]
interface rmc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] vertex_a;
  logic [7:0] vertex_b;
  logic       edge_valid;
  logic       last_edge;
  modport source (output valid, vertex_a, vertex_b, edge_valid, last_edge, input ready);
  modport sink (input valid, vertex_a, vertex_b, edge_valid, last_edge, output ready);
endinterface

interface rmc_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] min_cut;
  logic        graph_empty;
  logic        store_overflow;
  modport source (output valid, min_cut, graph_empty, store_overflow, input ready);
  modport sink (input valid, min_cut, graph_empty, store_overflow, output ready);
endinterface

[hdl/randomized_min_cut_contraction.sv]
// Karger min-cut engine.
// in: one edge request per cycle (vertex_a, vertex_b, edge_valid, last_edge).
//   Self-loops and out-of-range ids are dropped; edges beyond MAX_EDGES set
//   store_overflow. The request with last_edge starts a run; the input stalls
//   until the result request has been taken.
// out: one result per run: min_cut over the configured trials, graph_empty
//   when no edge was stored (no run is made then, result the next cycle).
// cfg: write enable, index (0 trials, 1 seed, 2 draw cap), 32-bit data.
// Operation: each trial clears the parent table, then each draw takes an
//   edge-index modulo (a compare and subtract per cycle) plus a union-find
//   walk in the parent memory that reads a root, or per path-halving hop
//   reads parent and grandparent and writes back; the cut count walks all edges
//   the same way. Everything is bound by the single port of the parent memory.
//   Loading runs at one edge per cycle while no result waits on out.
// Reset: sync, active low; control registers take their reset values, while
//   datapath ones and the stores need no clearing. The result is held while out.ready is low.
module randomized_min_cut_contraction (
  input  logic        clk,
  input  logic        rst_n,
  rmc_in_if.sink      in_ch,
  rmc_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import rmc_pkg::*;

  localparam int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EC_W = $clog2(MAX_EDGES + 1);
  localparam int PA_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int PV_W = $clog2(MAX_VERTICES + 1);

  logic [TRIAL_W-1:0] trials_cfg_r;
  logic [SEED_W-1:0]  seed_cfg_r;
  logic [DRAW_W-1:0]  draws_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trials_cfg_r <= TRIAL_W'(20);
      seed_cfg_r   <= SEED_W'(1);
      draws_cfg_r  <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TRIALS: trials_cfg_r <= cfg_data[TRIAL_W-1:0];
        CFG_SEED:   seed_cfg_r   <= cfg_data;
        CFG_DRAWS:  draws_cfg_r  <= cfg_data[DRAW_W-1:0];
        default: ;
      endcase
    end
  end

  // memories
  logic [15:0]     edge_mem [MAX_EDGES];
  logic [PA_W-1:0] par_mem  [MAX_VERTICES];
  logic            e_we;
  logic [EA_W-1:0] e_waddr, e_raddr;
  logic [15:0]     e_wdata, e_rdata_r;
  logic            p_we;
  logic [PA_W-1:0] p_addr, p_wdata, p_rdata_r;

  always_ff @(posedge clk) begin
    if (e_we) edge_mem[e_waddr] <= e_wdata;
    e_rdata_r <= edge_mem[e_raddr];
  end

  always_ff @(posedge clk) begin
    if (p_we) par_mem[p_addr] <= p_wdata;
    p_rdata_r <= par_mem[p_addr];
  end

  state_t state_r, state_nxt;
  logic [EC_W-1:0]    etot_r, etot_nxt;
  logic [7:0]         lv_r, lv_nxt;
  logic               ovf_r, ovf_nxt;
  logic [31:0]        lfsr_r, lfsr_nxt;
  logic [TRIAL_W-1:0] tleft_r, tleft_nxt;
  logic [DRAW_W-1:0]  draws_r, draws_nxt;
  logic [PV_W-1:0]    comp_r, comp_nxt;
  logic [CUT_W-1:0]   best_r, best_nxt, cut_r, cut_nxt;
  logic [EC_W-1:0]    idx_r, idx_nxt;
  logic [31:0]        rem_r, rem_nxt;
  logic [5:0]         mstep_r, mstep_nxt;
  logic [PA_W-1:0]    node_r, node_nxt, ra_r, ra_nxt, eb_r, eb_nxt;
  logic [PA_W-1:0]    prev_r, prev_nxt;
  logic               hop_r, hop_nxt;
  result_t            res_r, res_nxt;
  logic               ovalid_r, ovalid_nxt;

  logic in_fire, good_edge;
  logic [7:0] a8, b8;
  logic [PV_W-1:0] verts;
  logic [EC_W+31:0] div_sh;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign a8        = in_ch.vertex_a;
  assign b8        = in_ch.vertex_b;
  assign good_edge = in_ch.edge_valid && (a8 != b8) && (32'(a8) < MAX_VERTICES)
                     && (32'(b8) < MAX_VERTICES);
  assign verts     = PV_W'(lv_r) + PV_W'(1);
  assign in_ch.ready = (state_r == ST_LOAD) && !ovalid_r;

  // restoring modulo, one quotient bit per cycle
  assign div_sh = (EC_W+32)'(etot_r) << mstep_r[4:0];

  always_comb begin
    state_nxt = state_r;
    etot_nxt = etot_r; lv_nxt = lv_r; ovf_nxt = ovf_r; lfsr_nxt = lfsr_r;
    tleft_nxt = tleft_r; draws_nxt = draws_r; comp_nxt = comp_r;
    best_nxt = best_r; cut_nxt = cut_r; idx_nxt = idx_r; rem_nxt = rem_r;
    mstep_nxt = mstep_r; node_nxt = node_r; ra_nxt = ra_r; eb_nxt = eb_r;
    prev_nxt = prev_r; hop_nxt = hop_r;
    res_nxt = res_r; ovalid_nxt = ovalid_r;
    e_we = 1'b0; e_waddr = etot_r[EA_W-1:0];
    e_wdata = {b8, a8}; e_raddr = idx_r[EA_W-1:0];
    p_we = 1'b0; p_addr = node_r; p_wdata = node_r;

    if (ovalid_r && out_ch.ready) ovalid_nxt = 1'b0;

    unique case (state_r) inside
      ST_LOAD: begin
        if (in_fire) begin
          if (good_edge) begin
            if (32'(etot_r) >= MAX_EDGES) ovf_nxt = 1'b1;
            else begin
              e_we = 1'b1;
              etot_nxt = etot_r + EC_W'(1);
              if (a8 > lv_nxt) lv_nxt = a8;
              if (b8 > lv_nxt) lv_nxt = b8;
            end
          end
          if (in_ch.last_edge) begin
            if (etot_nxt == '0) begin
              res_nxt = '{min_cut: '0, graph_empty: 1'b1, store_overflow: ovf_nxt};
              ovalid_nxt = 1'b1;
              etot_nxt = '0; lv_nxt = '0; ovf_nxt = 1'b0;
            end else begin
              lfsr_nxt = (seed_cfg_r != '0) ? seed_cfg_r : 32'd1;
              tleft_nxt = (trials_cfg_r != '0) ? trials_cfg_r : TRIAL_W'(1);
              best_nxt = '1;
              node_nxt = '0;
              state_nxt = ST_INIT;
            end
          end
        end
      end
      ST_INIT: begin
        p_we = 1'b1; p_addr = node_r; p_wdata = node_r;
        if (PV_W'(node_r) == verts - PV_W'(1)) begin
          comp_nxt = verts; draws_nxt = '0; cut_nxt = '0; idx_nxt = '0;
          state_nxt = ST_DRAW;
        end else node_nxt = node_r + PA_W'(1);
      end
      ST_DRAW: begin
        if (comp_r > PV_W'(2) && draws_r < draws_cfg_r) begin
          lfsr_nxt = lfsr_step(lfsr_r);
          rem_nxt = lfsr_step(lfsr_r);
          draws_nxt = draws_r + DRAW_W'(1);
          mstep_nxt = 6'd31;
          state_nxt = ST_MOD;
        end else begin
          idx_nxt = '0;
          state_nxt = ST_CREAD;
        end
      end
      ST_MOD: begin
        if ((EC_W+32)'(rem_r) >= div_sh) rem_nxt = rem_r - div_sh[31:0];
        if (mstep_r == 6'd0) state_nxt = ST_EREAD;
        else mstep_nxt = mstep_r - 6'd1;
      end
      ST_EREAD: begin
        idx_nxt = EC_W'(rem_r);
        e_raddr = rem_r[EA_W-1:0];
        state_nxt = ST_EWAIT;
      end
      ST_EWAIT: begin
        node_nxt = e_rdata_r[PA_W-1:0];
        eb_nxt = e_rdata_r[8 +: PA_W];
        hop_nxt = 1'b0;
        state_nxt = ST_FINDA;
      end
      // find with path halving: read parent, read grandparent, write back
      ST_FINDA, ST_FINDB, ST_CFA, ST_CFB: begin
        p_addr = node_r;
        state_nxt = state_t'(state_r + 5'd1);
      end
      ST_FINDA_W, ST_FINDB_W, ST_CFA_W, ST_CFB_W: begin
        if (!hop_r) begin
          if (p_rdata_r == node_r) begin
            if (state_r == ST_FINDA_W) begin
              ra_nxt = node_r; node_nxt = eb_r; state_nxt = ST_FINDB;
            end else if (state_r == ST_FINDB_W) state_nxt = ST_LINK;
            else if (state_r == ST_CFA_W) begin
              ra_nxt = node_r; node_nxt = eb_r; state_nxt = ST_CFB;
            end else state_nxt = ST_CNEXT;
          end else begin
            prev_nxt = node_r; node_nxt = p_rdata_r; hop_nxt = 1'b1;
            p_addr = p_rdata_r;
          end
        end else begin
          // p_rdata_r is grandparent of prev_r
          p_we = 1'b1; p_addr = prev_r; p_wdata = p_rdata_r;
          node_nxt = p_rdata_r; hop_nxt = 1'b0;
          state_nxt = state_t'(state_r - 5'd1);
        end
      end
      ST_LINK: begin
        if (ra_r != node_r) begin
          p_we = 1'b1; p_addr = node_r; p_wdata = ra_r;
          comp_nxt = comp_r - PV_W'(1);
        end
        state_nxt = ST_DRAW;
      end
      ST_CREAD: begin
        if (idx_r == etot_r) state_nxt = ST_TEND;
        else begin
          e_raddr = idx_r[EA_W-1:0];
          state_nxt = ST_CWAIT;
        end
      end
      ST_CWAIT: begin
        node_nxt = e_rdata_r[PA_W-1:0];
        eb_nxt = e_rdata_r[8 +: PA_W];
        hop_nxt = 1'b0;
        state_nxt = ST_CFA;
      end
      ST_CNEXT: begin
        if (ra_r != node_r) cut_nxt = cut_r + CUT_W'(1);
        idx_nxt = idx_r + EC_W'(1);
        state_nxt = ST_CREAD;
      end
      ST_TEND: begin
        if (cut_r < best_r) best_nxt = cut_r;
        if (tleft_r == TRIAL_W'(1)) begin
          res_nxt = '{min_cut: (cut_r < best_r) ? cut_r : best_r,
                      graph_empty: 1'b0, store_overflow: ovf_r};
          state_nxt = ST_OUT;
        end else begin
          tleft_nxt = tleft_r - TRIAL_W'(1);
          node_nxt = '0;
          state_nxt = ST_INIT;
        end
      end
      ST_OUT: begin
        if (!ovalid_r) begin
          ovalid_nxt = 1'b1;
          etot_nxt = '0; lv_nxt = '0; ovf_nxt = 1'b0;
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD; etot_r <= '0; lv_r <= '0; ovf_r <= 1'b0;
      ovalid_r <= 1'b0; best_r <= '1; tleft_r <= '0; comp_r <= '0;
      lfsr_r <= 32'd1; hop_r <= 1'b0;
    end else begin
      state_r <= state_nxt; etot_r <= etot_nxt; lv_r <= lv_nxt; ovf_r <= ovf_nxt;
      ovalid_r <= ovalid_nxt; best_r <= best_nxt; tleft_r <= tleft_nxt;
      comp_r <= comp_nxt; lfsr_r <= lfsr_nxt; hop_r <= hop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    draws_r <= draws_nxt; cut_r <= cut_nxt; idx_r <= idx_nxt; rem_r <= rem_nxt;
    mstep_r <= mstep_nxt; node_r <= node_nxt; ra_r <= ra_nxt; eb_r <= eb_nxt;
    prev_r <= prev_nxt; res_r <= res_nxt;
  end

  assign out_ch.valid          = ovalid_r;
  assign out_ch.min_cut        = res_r.min_cut;
  assign out_ch.graph_empty    = res_r.graph_empty;
  assign out_ch.store_overflow = res_r.store_overflow;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_LOAD |-> !in_ch.ready) else $error("input taken during run");
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EREAD |-> rem_r < 32'(etot_r)) else $error("edge index out of range");
  a_comp_floor: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LINK |-> comp_r > PV_W'(2)) else $error("merge below two components");
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.graph_empty |-> out_ch.min_cut == '0)
    else $error("empty graph with nonzero cut");
endmodule
